@@ hdl/tmb_pkg.sv @@
// Shared types and constants for the timestamped message buffer.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package tmb_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int TIME_BITS_DEF    = 48;

    // Fixed port field widths
    localparam int OP_W  = 3;
    localparam int TS_W  = 48;
    localparam int PL_W  = 64;
    localparam int ST_W  = 3;
    localparam int OCC_W = 5;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_EXACT  = 3'd2,
        OP_BEFORE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_CAP_ZERO  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

@@ hdl/tmb_req_if.sv @@
// Request channel of the timestamped message buffer: valid/ready plus payload.
// Depends on tmb_pkg for field widths.
`default_nettype none

interface tmb_req_if import tmb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op;
    logic [TS_W-1:0] timestamp;
    logic [PL_W-1:0] payload_in;

    modport source (output valid, output op, output timestamp, output payload_in,
                    input ready);
    modport sink   (input valid, input op, input timestamp, input payload_in,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/tmb_res_if.sv @@
// Result channel of the timestamped message buffer: valid/ready plus payload.
// Depends on tmb_pkg for field widths.
`default_nettype none

interface tmb_res_if import tmb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [PL_W-1:0]  payload_out;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output payload_out, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input payload_out, input occupancy,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/timestamped_message_buffer.sv @@
// Timestamped message buffer: a bounded ring FIFO of keyed messages with a lookup scan.
// Depends on tmb_pkg, tmb_req_if and tmb_res_if.
//
// Usage: requests (op, timestamp, payload_in) enter on i_req; one result
// (status, payload_out, occupancy) leaves on o_res for every request.
// i_cfg_we/i_cfg_data write the capacity register; write it only while idle.
// The entries live in two synchronous RAMs (timestamps, messages) with one
// read port each, read every cycle at the same ring slot.
// One request is handled at a time. Clear, ignored codes, pushes at capacity
// zero, and pops and lookups on an empty buffer go from accept through S_FIN to
// the output register. Pop, exact lookup, before-lookup and push scan the stored
// entries one per cycle through the RAM read port; a scan stops at its first hit.
// A push without a duplicate then writes its entry in S_WRITE.
// Reset empties the buffer, sets capacity to 16 and drops any pending result.
// The result sits in an output register; if o_res stalls, one more request is
// still taken and worked off, then held in its final state until that
// register is free; no request after it is taken meanwhile.
`default_nettype none

module timestamped_message_buffer import tmb_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    tmb_req_if.sink               i_req,
    tmb_res_if.source             o_res
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SW    = CNT_W + 1;
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // ring slot of an entry: base + age mod DEPTH, sum stays below 2*DEPTH for ages up to DEPTH
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [CNT_W-1:0] age);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(age);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [TIME_BITS-1:0]    r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_word, n_word;
    logic [CAP_W-1:0]        r_cap;
    logic [AW-1:0]           r_oldest, n_oldest;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_age, n_age;
    logic [CNT_W-1:0]        r_left, n_left;
    logic                    r_fwd, n_fwd;
    logic                    r_cmp_vld, n_cmp_vld;
    logic                    r_cmp_last, n_cmp_last;
    t_status                 r_pend_status, n_pend_status;
    logic [PL_W-1:0]         r_pend_payload, n_pend_payload;
    logic                    r_out_vld, n_out_vld;
    t_status                 r_out_status, n_out_status;
    logic [PL_W-1:0]         r_out_payload, n_out_payload;
    logic [OCC_W-1:0]        r_out_occ, n_out_occ;

    logic [TIME_BITS-1:0]    r_time_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] r_msg_mem  [DEPTH];
    logic [TIME_BITS-1:0]    r_time_q;
    logic [PAYLOAD_BITS-1:0] r_msg_q;

    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] eff_cap;
    logic [CW-1:0] count_ext;
    logic          hit;

    assign eff_cap   = (CW'(r_cap) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(r_cap);
    assign count_ext = CW'(r_count);
    assign rd_addr   = wrap(r_oldest, r_age);
    assign wr_addr   = wrap(r_oldest, r_count);

    always_comb begin
        unique case (r_op)
            OP_POP:    hit = 1'b1;
            OP_BEFORE: hit = (r_time_q <= r_key);
            default:   hit = (r_time_q == r_key);
        endcase
    end

    // entry RAMs, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_time_mem[wr_addr] <= r_key;
            r_msg_mem[wr_addr]  <= r_word;
        end
        r_time_q <= r_time_mem[rd_addr];
        r_msg_q  <= r_msg_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap      <= CAP_RESET;
            r_oldest   <= '0;
            r_count    <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_oldest   <= n_oldest;
            r_count    <= n_count;
            r_cmp_vld  <= n_cmp_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
        r_op           <= n_op;
        r_key          <= n_key;
        r_word         <= n_word;
        r_age          <= n_age;
        r_left         <= n_left;
        r_fwd          <= n_fwd;
        r_cmp_last     <= n_cmp_last;
        r_pend_status  <= n_pend_status;
        r_pend_payload <= n_pend_payload;
        r_out_status   <= n_out_status;
        r_out_payload  <= n_out_payload;
        r_out_occ      <= n_out_occ;
    end

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_key          = r_key;
        n_word         = r_word;
        n_oldest       = r_oldest;
        n_count        = r_count;
        n_age          = r_age;
        n_left         = r_left;
        n_fwd          = r_fwd;
        n_cmp_vld      = r_cmp_vld;
        n_cmp_last     = r_cmp_last;
        n_pend_status  = r_pend_status;
        n_pend_payload = r_pend_payload;
        n_out_vld      = r_out_vld && !o_res.ready;
        n_out_status   = r_out_status;
        n_out_payload  = r_out_payload;
        n_out_occ      = r_out_occ;
        mem_we         = 1'b0;
        i_req.ready    = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op           = t_op'(i_req.op);
                    n_key          = TIME_BITS'(i_req.timestamp);
                    n_word         = PAYLOAD_BITS'(i_req.payload_in);
                    n_age          = '0;
                    n_left         = r_count;
                    n_fwd          = 1'b1;
                    n_cmp_vld      = 1'b0;
                    n_pend_status  = ST_OK;
                    n_pend_payload = '0;
                    n_state        = S_FIN;
                    unique case (t_op'(i_req.op))
                        OP_PUSH: begin
                            if (eff_cap == '0) begin
                                n_pend_status = ST_CAP_ZERO;
                            end else if (r_count == '0) begin
                                n_state = S_WRITE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_EXACT: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_BEFORE: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_EMPTY;
                            end else begin
                                // newest first
                                n_age   = r_count - CNT_W'(1);
                                n_fwd   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_oldest = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read; its data is compared in the following cycle
                if (r_left != '0) begin
                    n_left     = r_left - CNT_W'(1);
                    n_age      = r_fwd ? r_age + CNT_W'(1) : r_age - CNT_W'(1);
                    n_cmp_vld  = 1'b1;
                    n_cmp_last = (r_left == CNT_W'(1));
                end else begin
                    n_cmp_vld  = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (hit) begin
                        n_state = S_FIN;
                        if (r_op == OP_PUSH) begin
                            n_pend_status = ST_DUPLICATE;
                        end else begin
                            n_pend_payload = PL_W'(r_msg_q);
                            if (r_op == OP_POP) begin
                                n_oldest = wrap(r_oldest, CNT_W'(1));
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                    end else if (r_cmp_last) begin
                        if (r_op == OP_PUSH) begin
                            n_state = S_WRITE;
                        end else begin
                            n_pend_status = ST_NOT_FOUND;
                            n_state       = S_FIN;
                        end
                    end
                end
            end

            S_WRITE: begin
                // evicting keeps the count and moves oldest; the slot is the same
                mem_we = 1'b1;
                if (count_ext >= eff_cap) begin
                    n_oldest = wrap(r_oldest, CNT_W'(1));
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = S_FIN;
            end

            S_FIN: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld     = 1'b1;
                    n_out_status  = r_pend_status;
                    n_out_payload = r_pend_payload;
                    n_out_occ     = OCC_W'(r_count);
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.status      = r_out_status;
    assign o_res.payload_out = r_out_payload;
    assign o_res.occupancy   = r_out_occ;

endmodule

`default_nettype wire
